// ===== sv/mqtt_header_stream_parser_defines.svh =====
// ---------------------------------------------------------------------------
// MQTT header stream parser: assertion macros
// Shared property wrappers clocked on i_clk and disabled while i_rst_n is low.
// ---------------------------------------------------------------------------
`ifndef MQTT_HEADER_STREAM_PARSER_DEFINES_SVH
`define MQTT_HEADER_STREAM_PARSER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MHSP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MHSP_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/mhsp_pkg.sv =====
// ---------------------------------------------------------------------------
// MQTT header stream parser: package
// Parser phases, status codes, item and result types shared by the block.
// ---------------------------------------------------------------------------
package mhsp_pkg;

    typedef enum logic [2:0] {
        PH_IDLE       = 3'd0,
        PH_LEN        = 3'd1,
        PH_TOPIC_HI   = 3'd2,
        PH_TOPIC_LO   = 3'd3,
        PH_TOPIC_SKIP = 3'd4,
        PH_PID_HI     = 3'd5,
        PH_PID_LO     = 3'd6,
        PH_SKIP       = 3'd7
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_MALFORMED  = 2'd1,
        ST_NO_BUFFER  = 2'd2,
        ST_WRONG_TYPE = 2'd3
    } t_status;

    localparam logic [3:0]  TYPE_PUBLISH  = 4'd3;
    localparam logic [2:0]  MAX_LEN_BYTES = 3'd4;
    localparam logic [28:0] BUFFER_RESET  = 29'd1024;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first;
        logic [3:0] expected_type;
    } t_in_item;

    typedef struct packed {
        logic [3:0]  packet_type;
        logic        dup_flag;
        logic [1:0]  qos_level;
        logic        retain_flag;
        logic [27:0] remaining_length;
        logic [2:0]  header_length;
        logic [15:0] topic_length;
        logic [15:0] msg_id;
        logic [27:0] message_length;
        t_status     status;
    } t_result;

endpackage

// ===== sv/mhsp_if.sv =====
// ---------------------------------------------------------------------------
// MQTT header stream parser: channel interfaces
// Byte input, result output and configuration write channels.
// ---------------------------------------------------------------------------
interface mhsp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first;
    logic [3:0] expected_type;

    modport source (output valid, data_byte, first, expected_type, input ready);
    modport sink   (input valid, data_byte, first, expected_type, output ready);
endinterface

interface mhsp_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  packet_type;
    logic        dup_flag;
    logic [1:0]  qos_level;
    logic        retain_flag;
    logic [27:0] remaining_length;
    logic [2:0]  header_length;
    logic [15:0] topic_length;
    logic [15:0] msg_id;
    logic [27:0] message_length;
    logic [1:0]  status;

    modport source (output valid, packet_type, dup_flag, qos_level, retain_flag,
                    remaining_length, header_length, topic_length, msg_id,
                    message_length, status, input ready);
    modport sink   (input valid, packet_type, dup_flag, qos_level, retain_flag,
                    remaining_length, header_length, topic_length, msg_id,
                    message_length, status, output ready);
endinterface

interface mhsp_cfg_if;
    logic        valid;
    logic        ready;
    logic [28:0] buffer_bytes;

    modport source (output valid, buffer_bytes, input ready);
    modport sink   (input valid, buffer_bytes, output ready);
endinterface

// ===== sv/mhsp_core.sv =====
// ---------------------------------------------------------------------------
// MQTT header stream parser: parser core
// Per-byte state update of the header parser and assembly of the result.
// ---------------------------------------------------------------------------
`include "mqtt_header_stream_parser_defines.svh"

module mhsp_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  mhsp_pkg::t_in_item i_item,
    input  logic [28:0]       i_buffer_bytes,
    output logic              o_res_valid,
    output mhsp_pkg::t_result o_res
);

    mhsp_pkg::t_phase  r_phase, n_phase;
    logic [2:0]        r_cnt, n_cnt;
    logic [27:0]       r_acc, n_acc;
    logic [7:0]        r_taf, n_taf;
    logic [27:0]       r_bytes_left, n_bytes_left;
    logic [15:0]       r_topic, n_topic;
    logic [15:0]       r_tbl, n_tbl;
    logic [15:0]       r_pid, n_pid;
    logic              r_match, n_match;

    logic              w_emit;
    mhsp_pkg::t_status w_status;
    logic              w_publish;
    logic              w_qos_nz;
    logic [27:0]       w_group;
    logic [28:0]       w_total;
    logic [16:0]       w_vh;
    logic [28:0]       w_diff;
    logic [27:0]       w_msg;
    mhsp_pkg::t_phase  w_after_topic;

    assign w_publish     = (r_taf[7:4] == mhsp_pkg::TYPE_PUBLISH);
    assign w_qos_nz      = (r_taf[2:1] != 2'd0);
    assign w_after_topic = w_qos_nz ? mhsp_pkg::PH_PID_HI : mhsp_pkg::PH_SKIP;
    assign w_group       = 28'(i_item.data_byte[6:0]) << (5'd7 * {3'b000, r_cnt[1:0]});

    // Next state and the decision whether this byte closes a packet.
    always_comb begin
        n_phase      = r_phase;
        n_cnt        = r_cnt;
        n_acc        = r_acc;
        n_taf        = r_taf;
        n_bytes_left = r_bytes_left;
        n_topic      = r_topic;
        n_tbl        = r_tbl;
        n_pid        = r_pid;
        n_match      = r_match;
        w_emit       = 1'b0;
        w_status     = mhsp_pkg::ST_OK;
        w_total      = '0;
        if (i_item.first) begin
            n_taf        = i_item.data_byte;
            n_match      = (i_item.data_byte[7:4] == i_item.expected_type);
            n_cnt        = '0;
            n_acc        = '0;
            n_bytes_left = '0;
            n_topic      = '0;
            n_tbl        = '0;
            n_pid        = '0;
            n_phase      = mhsp_pkg::PH_LEN;
        end else if (r_phase == mhsp_pkg::PH_LEN) begin
            n_acc   = r_acc + w_group;
            n_cnt   = r_cnt + 3'd1;
            w_total = 29'(n_cnt) + 29'd1 + 29'(n_acc);
            if (i_item.data_byte[7]) begin
                if (n_cnt >= mhsp_pkg::MAX_LEN_BYTES) begin
                    w_emit   = 1'b1;
                    w_status = mhsp_pkg::ST_MALFORMED;
                end
            end else if (i_buffer_bytes < w_total) begin
                w_emit   = 1'b1;
                w_status = mhsp_pkg::ST_NO_BUFFER;
            end else if (!r_match) begin
                w_emit   = 1'b1;
                w_status = mhsp_pkg::ST_WRONG_TYPE;
            end else begin
                n_bytes_left = n_acc;
                if (n_acc == 28'd0) begin
                    // An empty PUBLISH cannot even hold its topic length.
                    w_emit   = 1'b1;
                    w_status = w_publish ? mhsp_pkg::ST_MALFORMED : mhsp_pkg::ST_OK;
                end else begin
                    n_phase = w_publish ? mhsp_pkg::PH_TOPIC_HI : mhsp_pkg::PH_SKIP;
                end
            end
        end else if (r_phase != mhsp_pkg::PH_IDLE) begin
            unique case (r_phase)
                mhsp_pkg::PH_TOPIC_HI: begin
                    n_topic = {i_item.data_byte, 8'h00};
                    n_phase = mhsp_pkg::PH_TOPIC_LO;
                end
                mhsp_pkg::PH_TOPIC_LO: begin
                    n_topic = {r_topic[15:8], i_item.data_byte};
                    n_tbl   = n_topic;
                    n_phase = (n_topic != 16'd0) ? mhsp_pkg::PH_TOPIC_SKIP : w_after_topic;
                end
                mhsp_pkg::PH_TOPIC_SKIP: begin
                    n_tbl = r_tbl - 16'd1;
                    if (n_tbl == 16'd0) begin
                        n_phase = w_after_topic;
                    end
                end
                mhsp_pkg::PH_PID_HI: begin
                    n_pid   = {i_item.data_byte, 8'h00};
                    n_phase = mhsp_pkg::PH_PID_LO;
                end
                mhsp_pkg::PH_PID_LO: begin
                    n_pid   = {r_pid[15:8], i_item.data_byte};
                    n_phase = mhsp_pkg::PH_SKIP;
                end
                default: begin
                end
            endcase
            n_bytes_left = r_bytes_left - 28'd1;
            if (n_bytes_left == 28'd0) begin
                // Ending before the variable header is complete is a short packet.
                w_emit   = 1'b1;
                w_status = (n_phase == mhsp_pkg::PH_SKIP) ? mhsp_pkg::ST_OK
                                                         : mhsp_pkg::ST_MALFORMED;
            end
        end
        if (w_emit) begin
            n_phase = mhsp_pkg::PH_IDLE;
        end
    end

    // Result assembly from the updated state.
    always_comb begin
        w_vh   = 17'(n_topic) + 17'd2 + (w_qos_nz ? 17'd2 : 17'd0);
        w_diff = {1'b0, r_acc} - 29'(w_vh);
        w_msg  = w_diff[28] ? 28'd0 : w_diff[27:0];
        o_res_valid            = w_emit;
        o_res.packet_type      = r_taf[7:4];
        o_res.dup_flag         = r_taf[3];
        o_res.qos_level        = r_taf[2:1];
        o_res.retain_flag      = r_taf[0];
        o_res.remaining_length = n_acc;
        o_res.header_length    = n_cnt + 3'd1;
        o_res.topic_length     = n_topic;
        o_res.msg_id           = n_pid;
        o_res.status           = w_status;
        if (w_status == mhsp_pkg::ST_OK && w_publish) begin
            o_res.message_length = w_msg;
        end else begin
            o_res.message_length = 28'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= mhsp_pkg::PH_IDLE;
            r_cnt        <= '0;
            r_acc        <= '0;
            r_taf        <= '0;
            r_bytes_left <= '0;
            r_topic      <= '0;
            r_tbl        <= '0;
            r_pid        <= '0;
            r_match      <= 1'b0;
        end else if (i_step) begin
            r_phase      <= n_phase;
            r_cnt        <= n_cnt;
            r_acc        <= n_acc;
            r_taf        <= n_taf;
            r_bytes_left <= n_bytes_left;
            r_topic      <= n_topic;
            r_tbl        <= n_tbl;
            r_pid        <= n_pid;
            r_match      <= n_match;
        end
    end

    `MHSP_ASSERT_NXT(a_emit_goes_idle, i_step && w_emit, r_phase == mhsp_pkg::PH_IDLE, "parser did not return to idle after a result")
    `MHSP_ASSERT_IMP(a_err_no_msg, w_emit && (w_status != mhsp_pkg::ST_OK), o_res.message_length == 28'd0, "message length reported with an error status")
    `MHSP_ASSERT_IMP(a_body_left, (r_phase != mhsp_pkg::PH_IDLE) && (r_phase != mhsp_pkg::PH_LEN), r_bytes_left != 28'd0, "body phase entered with no bytes left")

endmodule

// ===== sv/mhsp_out_reg.sv =====
// ---------------------------------------------------------------------------
// MQTT header stream parser: result register
// Holds one finished result until the downstream side takes it.
// ---------------------------------------------------------------------------
module mhsp_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  mhsp_pkg::t_result i_res,
    output logic              o_ready,
    output logic              o_valid,
    output mhsp_pkg::t_result o_res,
    input  logic              i_ready
);

    logic              r_valid;
    mhsp_pkg::t_result r_res;

    // Free when empty, or when the held result leaves in this cycle.
    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_res <= i_res;
        end
    end

endmodule

// ===== sv/mqtt_header_stream_parser.sv =====
// ---------------------------------------------------------------------------
// MQTT header stream parser
// Decodes the fixed header of each received MQTT packet, plus the topic length
// and packet id of PUBLISH packets, and reports at most one result per packet.
// ---------------------------------------------------------------------------
//   channel  | dir | transfer moves
//   ---------+-----+---------------------------------------------------
//   i_in     | in  | one packet byte, first-byte mark, expected type
//   o_out    | out | one result: header fields, lengths, status
//   i_cfg    | in  | receive buffer size (29 bits), always ready
//
// One byte per cycle unless o_out holds a result back: a byte lands in the
// input register, is parsed by the core once the result register can take a
// result, and any result is registered there. The rate is set by the per-byte
// state update in the parser core. Reset clears the parser to waiting for a
// first byte and the buffer size to 1024. When o_out holds a result back, one
// more byte is buffered and i_in drops ready until the result transfer completes.
// ---------------------------------------------------------------------------
module mqtt_header_stream_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mhsp_in_if.sink     i_in,
    mhsp_out_if.source  o_out,
    mhsp_cfg_if.sink    i_cfg
);

    logic               r_in_valid;
    mhsp_pkg::t_in_item r_in;
    logic [28:0]        r_buffer_bytes;
    logic               w_out_ready;
    logic               w_step;
    logic               w_res_valid;
    mhsp_pkg::t_result  w_res;
    mhsp_pkg::t_result  w_out_res;

    assign w_step     = r_in_valid && w_out_ready;
    assign i_in.ready = !r_in_valid || w_step;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_buffer_bytes <= mhsp_pkg::BUFFER_RESET;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (i_cfg.valid) begin
                r_buffer_bytes <= i_cfg.buffer_bytes;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in.data_byte     <= i_in.data_byte;
            r_in.first         <= i_in.first;
            r_in.expected_type <= i_in.expected_type;
        end
    end

    mhsp_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (w_step),
        .i_item         (r_in),
        .i_buffer_bytes (r_buffer_bytes),
        .o_res_valid    (w_res_valid),
        .o_res          (w_res)
    );

    mhsp_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_step && w_res_valid),
        .i_res   (w_res),
        .o_ready (w_out_ready),
        .o_valid (o_out.valid),
        .o_res   (w_out_res),
        .i_ready (o_out.ready)
    );

    assign o_out.packet_type      = w_out_res.packet_type;
    assign o_out.dup_flag         = w_out_res.dup_flag;
    assign o_out.qos_level        = w_out_res.qos_level;
    assign o_out.retain_flag      = w_out_res.retain_flag;
    assign o_out.remaining_length = w_out_res.remaining_length;
    assign o_out.header_length    = w_out_res.header_length;
    assign o_out.topic_length     = w_out_res.topic_length;
    assign o_out.msg_id           = w_out_res.msg_id;
    assign o_out.message_length   = w_out_res.message_length;
    assign o_out.status           = w_out_res.status;

endmodule

// ===== tb/sv/mhsp_header_checker.sv =====
// ---------------------------------------------------------------------------
// MQTT header stream parser: result checker
// Watches the byte, result and buffer-size channels, runs its own parser of
// the accepted bytes and compares every result transfer field by field with
// the oldest header it predicted.
// ---------------------------------------------------------------------------
module mhsp_header_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    mhsp_in_if   i_in,
    mhsp_out_if  i_out,
    mhsp_cfg_if  i_cfg,
    output int   o_fail_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    mhsp_pkg::t_phase phase;
    logic [2:0]       len_count;
    logic [27:0]      len_acc;
    logic [7:0]       flags_byte;
    logic [27:0]      bytes_left;
    logic [15:0]      topic_len;
    logic [15:0]      topic_left;
    logic [15:0]      pkt_id;
    logic             type_ok;
    logic [28:0]      buffer_size;

    mhsp_pkg::t_result header_q[$];
    int                fail_total    = 0;
    int                pending_count = 0;

    assign o_fail_count = fail_total;
    assign o_pending    = pending_count;

    function automatic logic qos_nonzero();
        return flags_byte[2:1] != 2'd0;
    endfunction

    task automatic close_packet(input mhsp_pkg::t_status st, input logic [27:0] msg);
        mhsp_pkg::t_result r;
        r.packet_type      = flags_byte[7:4];
        r.dup_flag         = flags_byte[3];
        r.qos_level        = flags_byte[2:1];
        r.retain_flag      = flags_byte[0];
        r.remaining_length = len_acc;
        r.header_length    = 3'd1 + len_count;
        r.topic_length     = topic_len;
        r.msg_id           = pkt_id;
        r.message_length   = msg;
        r.status           = st;
        header_q.push_back(r);
        phase = mhsp_pkg::PH_IDLE;
    endtask

    task automatic topic_done();
        if (qos_nonzero()) begin
            phase = mhsp_pkg::PH_PID_HI;
        end else begin
            phase = mhsp_pkg::PH_SKIP;
        end
    endtask

    task automatic parse_byte(input logic [7:0] b, input logic first, input logic [3:0] want_type);
        logic [29:0] need;
        logic [31:0] var_hdr;
        if (first) begin
            flags_byte = b;
            type_ok    = (b[7:4] == want_type);
            len_count  = '0;
            len_acc    = '0;
            bytes_left = '0;
            topic_len  = '0;
            topic_left = '0;
            pkt_id     = '0;
            phase      = mhsp_pkg::PH_LEN;
        end else if (phase == mhsp_pkg::PH_LEN) begin
            len_acc   = len_acc + (28'(b[6:0]) << (7 * len_count[1:0]));
            len_count = len_count + 3'd1;
            if (b[7]) begin
                if (len_count >= mhsp_pkg::MAX_LEN_BYTES) begin
                    close_packet(mhsp_pkg::ST_MALFORMED, '0);
                end
            end else begin
                need = 30'(len_count) + 30'd1 + 30'(len_acc);
                if (30'(buffer_size) < need) begin
                    close_packet(mhsp_pkg::ST_NO_BUFFER, '0);
                end else if (!type_ok) begin
                    close_packet(mhsp_pkg::ST_WRONG_TYPE, '0);
                end else begin
                    bytes_left = len_acc;
                    if (flags_byte[7:4] == mhsp_pkg::TYPE_PUBLISH) begin
                        if (bytes_left == '0) begin
                            close_packet(mhsp_pkg::ST_MALFORMED, '0);
                        end else begin
                            phase = mhsp_pkg::PH_TOPIC_HI;
                        end
                    end else if (bytes_left == '0) begin
                        close_packet(mhsp_pkg::ST_OK, '0);
                    end else begin
                        phase = mhsp_pkg::PH_SKIP;
                    end
                end
            end
        end else if (phase != mhsp_pkg::PH_IDLE) begin
            case (phase)
                mhsp_pkg::PH_TOPIC_HI: begin
                    topic_len = {b, 8'h00};
                    phase     = mhsp_pkg::PH_TOPIC_LO;
                end
                mhsp_pkg::PH_TOPIC_LO: begin
                    topic_len[7:0] = b;
                    topic_left     = topic_len;
                    if (topic_left != '0) begin
                        phase = mhsp_pkg::PH_TOPIC_SKIP;
                    end else begin
                        topic_done();
                    end
                end
                mhsp_pkg::PH_TOPIC_SKIP: begin
                    topic_left = topic_left - 16'd1;
                    if (topic_left == '0) topic_done();
                end
                mhsp_pkg::PH_PID_HI: begin
                    pkt_id = {b, 8'h00};
                    phase  = mhsp_pkg::PH_PID_LO;
                end
                mhsp_pkg::PH_PID_LO: begin
                    pkt_id[7:0] = b;
                    phase       = mhsp_pkg::PH_SKIP;
                end
                default: ;
            endcase
            bytes_left = bytes_left - 28'd1;
            if (bytes_left == '0) begin
                if (phase != mhsp_pkg::PH_SKIP) begin
                    // The packet ran out before its variable header was complete.
                    close_packet(mhsp_pkg::ST_MALFORMED, '0);
                end else if (flags_byte[7:4] == mhsp_pkg::TYPE_PUBLISH) begin
                    var_hdr = 32'd2 + 32'(topic_len) + (qos_nonzero() ? 32'd2 : 32'd0);
                    if (32'(len_acc) >= var_hdr) begin
                        close_packet(mhsp_pkg::ST_OK, 28'(32'(len_acc) - var_hdr));
                    end else begin
                        close_packet(mhsp_pkg::ST_OK, '0);
                    end
                end else begin
                    close_packet(mhsp_pkg::ST_OK, '0);
                end
            end
        end
    endtask

    task automatic check_field(input string name, input logic [27:0] want,
                               input logic [27:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            fail_total++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        mhsp_pkg::t_result want;
        if (!i_rst_n) begin
            phase       = mhsp_pkg::PH_IDLE;
            len_count   = '0;
            len_acc     = '0;
            flags_byte  = '0;
            bytes_left  = '0;
            topic_len   = '0;
            topic_left  = '0;
            pkt_id      = '0;
            type_ok     = 1'b0;
            buffer_size = mhsp_pkg::BUFFER_RESET;
            header_q.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) buffer_size = i_cfg.buffer_bytes;
            if (i_in.valid && i_in.ready) begin
                parse_byte(i_in.data_byte, i_in.first, i_in.expected_type);
            end
            if (i_out.valid && i_out.ready) begin
                if (header_q.size() == 0) begin
                    $display("%0t: result transfer with nothing pending, actual type %0h status %0d",
                             $time, i_out.packet_type, i_out.status);
                    fail_total++;
                end else begin
                    want = header_q.pop_front();
                    check_field("packet_type", 28'(want.packet_type),
                                28'(i_out.packet_type));
                    check_field("dup_flag", 28'(want.dup_flag), 28'(i_out.dup_flag));
                    check_field("qos_level", 28'(want.qos_level), 28'(i_out.qos_level));
                    check_field("retain_flag", 28'(want.retain_flag),
                                28'(i_out.retain_flag));
                    check_field("remaining_length", want.remaining_length,
                                i_out.remaining_length);
                    check_field("header_length", 28'(want.header_length),
                                28'(i_out.header_length));
                    check_field("topic_length", 28'(want.topic_length),
                                28'(i_out.topic_length));
                    check_field("msg_id", 28'(want.msg_id), 28'(i_out.msg_id));
                    check_field("message_length", want.message_length, i_out.message_length);
                    check_field("status", 28'(want.status), 28'(i_out.status));
                end
            end
        end
        pending_count = header_q.size();
    end

endmodule

// ===== tb/sv/tb_mqtt_header_stream_parser.sv =====
// ---------------------------------------------------------------------------
// MQTT header stream parser: testbench top
// Feeds directed and random MQTT packets in bursts, stalls the result side
// on its own pattern with long hold-offs on request, steps the buffer size through
// its extremes and random values between phases, and reports the verdict.
// ---------------------------------------------------------------------------
module tb_mqtt_header_stream_parser;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN       = 10;
    localparam int ITEM_TARGET = 750;

    logic i_clk = 1'b0;
    logic i_rst_n;

    mhsp_in_if  in_ch ();
    mhsp_out_if out_ch ();
    mhsp_cfg_if cfg_ch ();

    int fail_count;
    int pending;

    int         idle_cycles = 0;
    int         burst_left  = 0;
    int         sent_items  = 0;
    bit         hold_req    = 1'b0;
    logic [7:0] pkt[$];

    mqtt_header_stream_parser u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    mhsp_header_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .i_cfg        (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Ends the run when no transfer of any kind has happened for too long.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
            $display("FAILURE");
            $finish;
        end
    end

    // Result side: stretches of steady, random and sparse ready, plus a long
    // hold-off on request so that the parser backs up and stalls its input.
    initial begin : receiver
        int mode;
        int span;
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                mode = $urandom_range(0, 2);
                span = $urandom_range(10, 80);
                repeat (span) begin
                    case (mode)
                        0:       out_ch.ready <= 1'b1;
                        1:       out_ch.ready <= 1'($urandom_range(0, 1));
                        default: out_ch.ready <= ($urandom_range(0, 3) == 0);
                    endcase
                    @(posedge i_clk);
                end
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic first, input logic [3:0] want_type);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 20);
        end
        in_ch.valid         <= 1'b1;
        in_ch.data_byte     <= b;
        in_ch.first         <= first;
        in_ch.expected_type <= want_type;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        burst_left--;
    endtask

    task automatic send_pkt(input logic [3:0] want_type);
        foreach (pkt[i]) begin
            send_byte(pkt[i], i == 0, want_type);
            sent_items++;
        end
    endtask

    // Remaining length in 7-bit groups, low group first, optionally padded
    // with zero groups up to the four-byte limit.
    task automatic push_length(input int unsigned len, input int pad);
        int         groups;
        logic [7:0] g;
        groups = (len < 128) ? 1 : (len < 16384) ? 2 : (len < 2097152) ? 3 : 4;
        groups = groups + pad;
        if (groups > 4) groups = 4;
        for (int i = 0; i < groups; i++) begin
            g = {1'b0, 7'(len >> (7 * i))};
            if (i < groups - 1) g[7] = 1'b1;
            pkt.push_back(g);
        end
    endtask

    task automatic random_packet();
        logic [3:0]  ptype;
        logic [3:0]  pflags;
        logic [3:0]  want;
        logic [7:0]  body[$];
        int unsigned tl;
        int unsigned wf_len;
        int unsigned rem;
        int unsigned nsend;
        int          kind;
        int          pad;
        pkt.delete();
        ptype  = ($urandom_range(0, 9) < 4) ? mhsp_pkg::TYPE_PUBLISH
                                            : 4'($urandom_range(0, 15));
        pflags = 4'($urandom_range(0, 15));
        want   = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15)) : ptype;
        pkt.push_back({ptype, pflags});
        kind = $urandom_range(0, 99);
        if (kind < 6) begin
            // Runaway length: every length byte claims another one follows.
            repeat (4) pkt.push_back(8'h80 | 8'($urandom_range(0, 127)));
            repeat ($urandom_range(0, 3)) pkt.push_back(8'($urandom));
        end else begin
            if (ptype == mhsp_pkg::TYPE_PUBLISH) begin
                tl = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 65535)
                                                  : $urandom_range(0, 6);
                body.push_back(8'(tl >> 8));
                body.push_back(8'(tl));
                repeat ((tl < 40) ? tl : 40) body.push_back(8'($urandom));
                if (pflags[2:1] != 2'd0) begin
                    body.push_back(8'($urandom));
                    body.push_back(8'($urandom));
                end
                wf_len = 2 + tl + ((pflags[2:1] != 2'd0) ? 2 : 0) + $urandom_range(0, 8);
            end else begin
                wf_len = $urandom_range(0, 10);
            end
            if (kind < 16) begin
                rem = $urandom_range(0, wf_len);
            end else if (kind < 22) begin
                rem = $urandom_range(0, 268435455);
            end else begin
                rem = wf_len;
            end
            pad = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0;
            push_length(rem, pad);
            if (rem > 40) begin
                nsend = $urandom_range(0, 6);
            end else if (kind < 30) begin
                // Cut short: the next first byte drops this packet.
                nsend = $urandom_range(0, rem);
            end else begin
                nsend = rem;
            end
            for (int i = 0; i < nsend; i++) begin
                pkt.push_back((i < body.size()) ? body[i] : 8'($urandom));
            end
        end
        send_pkt(want);
    endtask

    task automatic run_random(input int n_items);
        int target;
        target = sent_items + n_items;
        while (sent_items < target) begin
            if ($urandom_range(0, 11) == 0) begin
                repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0, 4'($urandom));
            end else begin
                random_packet();
            end
        end
    endtask

    // Stops the byte stream and waits until every predicted result has
    // arrived and any byte still in flight has been parsed.
    task automatic settle();
        in_ch.valid <= 1'b0;
        burst_left = 0;
        repeat (2) @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic write_buffer(input logic [28:0] size);
        cfg_ch.valid        <= 1'b1;
        cfg_ch.buffer_bytes <= size;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    initial begin : stimulus
        logic [28:0] size;
        i_rst_n             <= 1'b0;
        in_ch.valid         <= 1'b0;
        in_ch.data_byte     <= '0;
        in_ch.first         <= 1'b0;
        in_ch.expected_type <= '0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.buffer_bytes <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, with the buffer size left at its reset value.
        send_byte(8'hFF, 1'b0, 4'hF);          // stray byte while waiting
        pkt = '{8'hC0, 8'h00};                 // empty packet
        send_pkt(4'd12);
        pkt = '{8'h3F, 8'h05, 8'h00, 8'h00, 8'hAB, 8'hCD, 8'h7E};  // QoS 3 publish
        send_pkt(mhsp_pkg::TYPE_PUBLISH);
        pkt = '{8'h30, 8'h00};                 // publish with nothing after the header
        send_pkt(mhsp_pkg::TYPE_PUBLISH);
        pkt = '{8'hF0, 8'hFF, 8'hFF, 8'hFF, 8'hFF};  // too many length bytes
        send_pkt(4'd15);
        pkt = '{8'h20, 8'hFF, 8'hFF, 8'hFF, 8'h7F};  // largest length, too big
        send_pkt(4'd2);
        pkt = '{8'h20, 8'h05};                 // dropped by the next first byte
        send_pkt(4'd2);
        pkt = '{8'h90, 8'h00};                 // wrong type
        send_pkt(4'd1);

        hold_req = 1'b1;
        run_random(150);

        settle();
        write_buffer(29'd2);
        run_random(90);

        settle();
        write_buffer(29'd268435460);
        pkt = '{8'h20, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'h11, 8'h22};  // fits, then dropped
        send_pkt(4'd2);
        run_random(90);

        while (sent_items < ITEM_TARGET) begin
            settle();
            case ($urandom_range(0, 2))
                0:       size = 29'($urandom_range(2, 40));
                1:       size = 29'($urandom_range(2, 2000));
                default: size = 29'($urandom_range(2, 268435460));
            endcase
            write_buffer(size);
            if ($urandom_range(0, 3) == 0) hold_req = 1'b1;
            run_random(100);
        end

        settle();
        if (fail_count == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            if (pending != 0) $display("%0t: %0d predicted results never arrived", $time, pending);
            $display("FAILURE");
        end
        $finish;
    end

endmodule
